### sv/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared constants, codes and controller/datapath interface types for the
// random sample multiset.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int OUT_CW   = 11;
    localparam int VAL_W    = 32;
    localparam int RND_W    = 31;
    localparam int DIV_W    = $clog2(RND_W + 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_COUNT  = 2'd2,
        ACT_SAMPLE = 2'd3
    } action_t;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic dscan;
        logic decide;
        logic escan;
        logic last_rd;
        logic move;
        logic div;
        logic smp_rd;
        logic smp_cap;
        logic publish;
    } rsm_cmd_t;

    typedef struct packed {
        logic    clr_done;
        logic    dscan_done;
        action_t act;
        logic    rm_go;
        logic    smp_go;
        logic    escan_done;
        logic    escan_hit;
        logic    div_done;
        logic    out_free;
    } rsm_sts_t;

endpackage

### sv/rsm_ctrl.sv
// ----------------------------------------------------------------------------
// rsm_ctrl
// Sequencer: clearing pass, key scan, decision, element scan and move,
// modulo for sampling, and hand-off to the output register.
// ----------------------------------------------------------------------------
module rsm_ctrl
    import rsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rsm_sts_t sts,
    output rsm_cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_DSCAN  = 11'b000_0000_0100,
        ST_DECIDE = 11'b000_0000_1000,
        ST_ESCAN  = 11'b000_0001_0000,
        ST_LRD    = 11'b000_0010_0000,
        ST_MOVE   = 11'b000_0100_0000,
        ST_DIV    = 11'b000_1000_0000,
        ST_SRD    = 11'b001_0000_0000,
        ST_SCAP   = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DSCAN;
                end
            end
            ST_DSCAN:
            begin
                cmd.dscan = 1'b1;
                if (sts.dscan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_OUT;
                if (sts.act == ACT_REMOVE && sts.rm_go)
                begin
                    state_next = ST_ESCAN;
                end
                else if (sts.act == ACT_SAMPLE && sts.smp_go)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_ESCAN:
            begin
                cmd.escan = 1'b1;
                if (sts.escan_done)
                begin
                    state_next = sts.escan_hit ? ST_LRD : ST_OUT;
                end
            end
            ST_LRD:
            begin
                cmd.last_rd = 1'b1;
                state_next  = ST_MOVE;
            end
            ST_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = ST_OUT;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                cmd.smp_rd = 1'b1;
                state_next = ST_SCAP;
            end
            ST_SCAP:
            begin
                cmd.smp_cap = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### sv/rsm_dpath.sv
// ----------------------------------------------------------------------------
// rsm_dpath
// Element and key stores, scan pipelines, restoring modulo unit, result and
// output registers.
// ----------------------------------------------------------------------------
module rsm_dpath
    import rsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  rsm_cmd_t                 cmd,
    output rsm_sts_t                 sts,
    input  logic [1:0]               action,
    input  logic signed [VAL_W-1:0]  item_value,
    input  logic [RND_W-1:0]         random_word,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     success,
    output logic [OUT_CW-1:0]        value_count,
    output logic [OUT_CW-1:0]        total_size,
    output logic signed [VAL_W-1:0]  sampled_value,
    output logic [1:0]               error_code
);

    logic [VAL_W-1:0] ev_mem [CAPACITY];
    logic [IDX_W-1:0] er_mem [CAPACITY];
    logic [VAL_W-1:0] dk_mem [CAPACITY];
    logic [CNT_W-1:0] dc_mem [CAPACITY];
    logic             dv_mem [CAPACITY];

    action_t          act_reg;
    logic [VAL_W-1:0] val_reg;
    logic [RND_W-1:0] rnd_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] clr_reg;

    logic [CNT_W-1:0] scan_reg;
    logic             dpv_reg;
    logic [IDX_W-1:0] daddr_reg;
    logic [VAL_W-1:0] dk_q;
    logic [CNT_W-1:0] dc_q;
    logic             dv_q;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_slot_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_slot_reg;

    logic [CNT_W-1:0] ecnt_reg;
    logic             epv_reg;
    logic [IDX_W-1:0] eaddr_reg;
    logic             efound_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [VAL_W-1:0] ev_q;
    logic [IDX_W-1:0] er_q;

    logic [CNT_W-1:0] rem_reg;
    logic [DIV_W-1:0] dleft_reg;

    logic             r_success_reg;
    logic [CNT_W-1:0] r_count_reg;
    logic [VAL_W-1:0] r_sampled_reg;
    logic [1:0]       r_err_reg;

    logic             out_valid_reg;
    logic             o_success_reg;
    logic [OUT_CW-1:0] o_count_reg;
    logic [OUT_CW-1:0] o_total_reg;
    logic [VAL_W-1:0] o_sampled_reg;
    logic [1:0]       o_err_reg;

    logic             full;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] want;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic [IDX_W-1:0] ins_slot;
    logic             ins_ok;
    logic             clr_act;
    logic             d_match;
    logic             e_match;
    logic [IDX_W-1:0] ev_ra;
    logic [DIV_W-1:0] bit_idx;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   trial_sub;
    logic             dv_we;
    logic [IDX_W-1:0] dv_wa;
    logic             dv_wd;
    logic             dc_we;
    logic [IDX_W-1:0] dc_wa;
    logic             ev_we;
    logic [IDX_W-1:0] ev_wa;

    assign full     = total_reg >= CNT_W'(CAPACITY);
    assign last_idx = IDX_W'(total_reg - 1'b1);
    assign want     = IDX_W'(hit_cnt_reg - 1'b1);
    assign cur_cnt  = hit_reg ? hit_cnt_reg : '0;
    assign new_cnt  = hit_reg ? (hit_cnt_reg + 1'b1) : CNT_W'(1);
    assign ins_slot = hit_reg ? hit_slot_reg : free_slot_reg;
    assign ins_ok   = cmd.decide && act_reg == ACT_INSERT && !full && (hit_reg || free_reg);
    assign clr_act  = cmd.clr && clr_reg < CNT_W'(CAPACITY);
    assign d_match  = dpv_reg && dv_q && dk_q == val_reg;
    assign e_match  = epv_reg && ev_q == val_reg && er_q == want;

    assign ev_ra = cmd.last_rd ? last_idx :
                   cmd.smp_rd  ? rem_reg[IDX_W-1:0] : ecnt_reg[IDX_W-1:0];

    assign bit_idx   = DIV_W'(dleft_reg - 1'b1);
    assign trial     = {rem_reg, rnd_reg[bit_idx]};
    assign trial_sub = trial - {1'b0, total_reg};

    assign dv_we = clr_act || ins_ok || cmd.move;
    assign dv_wa = clr_act ? clr_reg[IDX_W-1:0] : (cmd.move ? hit_slot_reg : ins_slot);
    assign dv_wd = clr_act ? 1'b0 : (cmd.move ? (want != '0) : 1'b1);
    assign dc_we = ins_ok || cmd.move;
    assign dc_wa = cmd.move ? hit_slot_reg : ins_slot;
    assign ev_we = ins_ok || cmd.move;
    assign ev_wa = cmd.move ? pos_reg : total_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (dv_we)
        begin
            dv_mem[dv_wa] <= dv_wd;
        end
        if (ins_ok)
        begin
            dk_mem[ins_slot] <= val_reg;
        end
        if (dc_we)
        begin
            dc_mem[dc_wa] <= cmd.move ? CNT_W'(want) : new_cnt;
        end
        dv_q <= dv_mem[scan_reg[IDX_W-1:0]];
        dk_q <= dk_mem[scan_reg[IDX_W-1:0]];
        dc_q <= dc_mem[scan_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ev_we)
        begin
            ev_mem[ev_wa] <= cmd.move ? ev_q : val_reg;
            er_mem[ev_wa] <= cmd.move ? er_q : (hit_reg ? IDX_W'(hit_cnt_reg) : '0);
        end
        ev_q <= ev_mem[ev_ra];
        er_q <= er_mem[ev_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            clr_reg       <= '0;
            scan_reg      <= '0;
            dpv_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            ecnt_reg      <= '0;
            epv_reg       <= 1'b0;
            efound_reg    <= 1'b0;
            dleft_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_act)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                scan_reg   <= '0;
                dpv_reg    <= 1'b0;
                hit_reg    <= 1'b0;
                free_reg   <= 1'b0;
                ecnt_reg   <= '0;
                epv_reg    <= 1'b0;
                efound_reg <= 1'b0;
                dleft_reg  <= DIV_W'(RND_W);
            end
            if (cmd.dscan)
            begin
                if (scan_reg < CNT_W'(CAPACITY))
                begin
                    scan_reg <= scan_reg + 1'b1;
                    dpv_reg  <= 1'b1;
                end
                else
                begin
                    dpv_reg <= 1'b0;
                end
                if (d_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (dpv_reg && !dv_q && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.escan)
            begin
                if (!efound_reg && ecnt_reg < total_reg)
                begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                    epv_reg  <= 1'b1;
                end
                else
                begin
                    epv_reg <= 1'b0;
                end
                if (e_match && !efound_reg)
                begin
                    efound_reg <= 1'b1;
                end
            end
            if (cmd.div && dleft_reg != '0)
            begin
                dleft_reg <= dleft_reg - 1'b1;
            end
            if (ins_ok)
            begin
                total_reg <= total_reg + 1'b1;
            end
            else if (cmd.move)
            begin
                total_reg <= total_reg - 1'b1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action_t'(action);
            val_reg <= item_value;
            rnd_reg <= random_word;
            rem_reg <= '0;
        end
        if (cmd.dscan)
        begin
            daddr_reg <= scan_reg[IDX_W-1:0];
            if (d_match && !hit_reg)
            begin
                hit_slot_reg <= daddr_reg;
                hit_cnt_reg  <= dc_q;
            end
            if (dpv_reg && !dv_q && !free_reg)
            begin
                free_slot_reg <= daddr_reg;
            end
        end
        if (cmd.escan)
        begin
            eaddr_reg <= ecnt_reg[IDX_W-1:0];
            if (e_match && !efound_reg)
            begin
                pos_reg <= eaddr_reg;
            end
        end
        if (cmd.div && dleft_reg != '0)
        begin
            rem_reg <= trial_sub[CNT_W] ? trial[CNT_W-1:0] : trial_sub[CNT_W-1:0];
        end
        if (cmd.decide)
        begin
            r_sampled_reg <= '0;
            case (act_reg)
                ACT_INSERT:
                begin
                    r_success_reg <= !full && !hit_reg;
                    r_count_reg   <= ins_ok ? new_cnt : cur_cnt;
                    r_err_reg     <= full ? ERR_FULL : ERR_NONE;
                end
                ACT_REMOVE:
                begin
                    r_success_reg <= 1'b0;
                    r_count_reg   <= '0;
                    r_err_reg     <= ERR_NONE;
                end
                ACT_SAMPLE:
                begin
                    r_success_reg <= 1'b1;
                    r_count_reg   <= cur_cnt;
                    r_err_reg     <= (total_reg == '0) ? ERR_EMPTY : ERR_NONE;
                end
                default:
                begin
                    r_success_reg <= 1'b1;
                    r_count_reg   <= cur_cnt;
                    r_err_reg     <= ERR_NONE;
                end
            endcase
        end
        if (cmd.move)
        begin
            r_success_reg <= 1'b1;
            r_count_reg   <= CNT_W'(want);
        end
        if (cmd.smp_cap)
        begin
            r_sampled_reg <= ev_q;
        end
        if (cmd.publish)
        begin
            o_success_reg <= r_success_reg;
            o_count_reg   <= OUT_CW'(r_count_reg);
            o_total_reg   <= OUT_CW'(total_reg);
            o_sampled_reg <= r_sampled_reg;
            o_err_reg     <= r_err_reg;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.clr_done   = clr_reg >= CNT_W'(CAPACITY);
        sts.dscan_done = scan_reg >= CNT_W'(CAPACITY) && !dpv_reg;
        sts.act        = act_reg;
        sts.rm_go      = hit_reg && hit_cnt_reg != '0 && total_reg != '0;
        sts.smp_go     = total_reg != '0;
        sts.escan_done = efound_reg || (ecnt_reg >= total_reg && !epv_reg);
        sts.escan_hit  = efound_reg;
        sts.div_done   = dleft_reg == '0;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign success       = o_success_reg;
    assign value_count   = o_count_reg;
    assign total_size    = o_total_reg;
    assign sampled_value = o_sampled_reg;
    assign error_code    = o_err_reg;

endmodule

### sv/random_sample_multiset_top.sv
// ----------------------------------------------------------------------------
// random_sample_multiset_top
// Bounded multiset with duplicates and uniform random sampling.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat carries action, item_value and
// random_word. Output channel (out_valid/out_ready): one result beat per
// input beat, in order.
// Each item first walks the whole key table through its read port, one
// entry a cycle. Insert and count query then go straight to the result.
// Sample adds a restoring modulo and a read of the element store. Remove
// adds a walk of the element store up to the matching position, at most
// total_size entries, then a move of the last element into that place.
// One item is in work at a time; in_ready is high only when the sequencer is
// idle, entered as the result moves to the output register. The result
// sits in that register, so the next beat is taken while a result waits; a
// finished item waits for that register to drain when the receiver stalls.
// After reset the key valid store is swept clear with in_ready low; the
// block then holds no elements.
// ----------------------------------------------------------------------------
module random_sample_multiset_top
    import rsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               action,
    input  logic signed [VAL_W-1:0]  item_value,
    input  logic [RND_W-1:0]         random_word,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     success,
    output logic [OUT_CW-1:0]        value_count,
    output logic [OUT_CW-1:0]        total_size,
    output logic signed [VAL_W-1:0]  sampled_value,
    output logic [1:0]               error_code
);

    rsm_cmd_t cmd;
    rsm_sts_t sts;

    rsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsm_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .item_value    (item_value),
        .random_word   (random_word),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .success       (success),
        .value_count   (value_count),
        .total_size    (total_size),
        .sampled_value (sampled_value),
        .error_code    (error_code)
    );

endmodule

### sv/rsm_checker.sv
// ----------------------------------------------------------------------------
// rsm_checker
// Port-level checks for the random sample multiset, bound to the top level.
// ----------------------------------------------------------------------------
module rsm_checker
    import rsm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    success,
    input logic [OUT_CW-1:0]       value_count,
    input logic [OUT_CW-1:0]       total_size,
    input logic signed [VAL_W-1:0] sampled_value,
    input logic [1:0]              error_code
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_count)
            && $stable(total_size) && $stable(sampled_value))
        else $error("result beat changed while stalled");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_code == ERR_NONE || error_code == ERR_FULL
            || error_code == ERR_EMPTY)
        else $error("bad error code");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_FULL |-> !success
            && total_size == OUT_CW'(CAPACITY))
        else $error("full reported below capacity");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_EMPTY |-> sampled_value == '0
            && total_size == '0)
        else $error("empty reported with elements held");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> value_count <= total_size)
        else $error("value count above total size");

endmodule

bind random_sample_multiset_top rsm_checker u_rsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .value_count   (value_count),
    .total_size    (total_size),
    .sampled_value (sampled_value),
    .error_code    (error_code)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, remove, count and sample beats into the multiset, keeps a
// behavioral copy of the element store to predict every result, and compares
// each result beat field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
class multiset_scoreboard;
    typedef struct {
        logic        success;
        logic [10:0] value_count;
        logic [10:0] total_size;
        logic [31:0] sampled_value;
        logic [1:0]  error_code;
    } result_t;

    logic [31:0] elem_val[rsm_pkg::CAPACITY];
    int          elem_rank[rsm_pkg::CAPACITY];
    int          elem_total;
    int          key_count[logic [31:0]];
    result_t     pending[$];
    int          errors;

    function void note_beat(logic [1:0] act, logic [31:0] val, logic [30:0] rnd);
        result_t r;
        int      cnt;
        int      i;
        r = '{1'b1, 11'd0, 11'd0, 32'd0, rsm_pkg::ERR_NONE};
        cnt = key_count.exists(val) ? key_count[val] : 0;
        if (act == rsm_pkg::ACT_INSERT)
        begin
            if (elem_total >= rsm_pkg::CAPACITY)
            begin
                r.success = 0;
                r.error_code = rsm_pkg::ERR_FULL;
            end
            else
            begin
                r.success = (cnt == 0);
                elem_val[elem_total] = val;
                elem_rank[elem_total] = cnt;
                elem_total++;
                cnt++;
                key_count[val] = cnt;
            end
        end
        else if (act == rsm_pkg::ACT_REMOVE)
        begin
            if (cnt == 0)
            begin
                r.success = 0;
            end
            else
            begin
                for (i = 0; i < elem_total; i++)
                    if (elem_val[i] == val && elem_rank[i] == cnt - 1)
                        break;
                if (i < elem_total)
                begin
                    elem_val[i] = elem_val[elem_total - 1];
                    elem_rank[i] = elem_rank[elem_total - 1];
                    elem_total--;
                    cnt--;
                    if (cnt == 0)
                        key_count.delete(val);
                    else
                        key_count[val] = cnt;
                end
                else
                begin
                    r.success = 0;
                end
            end
        end
        else if (act == rsm_pkg::ACT_SAMPLE)
        begin
            if (elem_total == 0)
                r.error_code = rsm_pkg::ERR_EMPTY;
            else
                r.sampled_value = elem_val[rnd % elem_total];
        end
        r.value_count = 11'(cnt);
        r.total_size = 11'(elem_total);
        pending.insert(pending.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_beat(logic s, logic [10:0] c, logic [10:0] t, logic [31:0] v, logic [1:0] e);
        result_t r;
        if (pending.size() == 0)
        begin
            report("unexpected beat", 0, 0);
            return;
        end
        r = pending.pop_front();
        if (s !== r.success) report("success", s, r.success);
        if (c !== r.value_count) report("value_count", c, r.value_count);
        if (t !== r.total_size) report("total_size", t, r.total_size);
        if (v !== r.sampled_value) report("sampled_value", v, r.sampled_value);
        if (e !== r.error_code) report("error_code", e, r.error_code);
    endtask
endclass

module tb_top;
    import rsm_pkg::*;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_ready;
    logic [1:0]        action = ACT_COUNT;
    logic signed [31:0] item_value = 0;
    logic [30:0]       random_word = 0;
    logic              out_valid;
    logic              out_ready = 0;
    logic              success;
    logic [10:0]       value_count;
    logic [10:0]       total_size;
    logic signed [31:0] sampled_value;
    logic [1:0]        error_code;

    multiset_scoreboard sb = new();
    logic [31:0] pool[8];
    bit          calm = 0;
    bit          stim_done = 0;

    random_sample_multiset_top DUT (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function bit idle_now();
        return !calm && ($urandom_range(0, 99) < 34);
    endfunction

    task send_beat(logic [1:0] act, logic [31:0] val, logic [30:0] rnd);
        if (idle_now())
        begin
            in_valid <= 0;
            do @(posedge clk); while (idle_now());
        end
        action <= act;
        item_value <= val;
        random_word <= rnd;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_beat(act, val, rnd);
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return pool[$urandom_range(0, 7)];
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_beat(success, value_count, total_size, sampled_value, error_code);
        out_ready <= rst_n && !idle_now();
    end

    initial
    begin
        int n;
        int k;
        logic [1:0] act;
        for (k = 0; k < 8; k++) pool[k] = $urandom;
        pool[0] = 0;
        pool[1] = 32'hffff_ffff;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: empty cases, extremes, duplicates, removing the final element
        send_beat(ACT_SAMPLE, 32'd0, 31'h7fff_ffff);
        send_beat(ACT_REMOVE, 32'd5, 31'd0);
        send_beat(ACT_COUNT, 32'h8000_0000, 31'd0);
        send_beat(ACT_INSERT, 32'h8000_0000, 31'd0);
        send_beat(ACT_INSERT, 32'h7fff_ffff, 31'd0);
        send_beat(ACT_INSERT, 32'h8000_0000, 31'd0);
        send_beat(ACT_INSERT, 32'd0, 31'd0);
        send_beat(ACT_INSERT, 32'hffff_ffff, 31'd0);
        send_beat(ACT_COUNT, 32'h8000_0000, 31'd0);
        send_beat(ACT_SAMPLE, 32'd0, 31'h7fff_ffff);
        send_beat(ACT_SAMPLE, 32'h1234, 31'd0);
        send_beat(ACT_SAMPLE, 32'd0, 31'h5555_5555);
        send_beat(ACT_REMOVE, 32'hffff_ffff, 31'd0);
        send_beat(ACT_REMOVE, 32'h8000_0000, 31'd0);
        send_beat(ACT_REMOVE, 32'h7fff_ffff, 31'd0);
        send_beat(ACT_REMOVE, 32'h7fff_ffff, 31'd0);
        send_beat(ACT_REMOVE, 32'h8000_0000, 31'd0);
        send_beat(ACT_REMOVE, 32'd0, 31'd0);
        send_beat(ACT_SAMPLE, 32'd0, 31'd1);
        // random, with a calm stretch in the middle
        for (n = 0; n < 540; n++)
        begin
            calm = (n >= 200 && n < 260);
            k = $urandom_range(0, 99);
            act = k < 45 ? ACT_INSERT : k < 75 ? ACT_REMOVE : k < 85 ? ACT_COUNT : ACT_SAMPLE;
            send_beat(act, pick_value(), 31'($urandom));
        end
        calm = 0;
        send_beat(ACT_SAMPLE, 32'd0, 31'h7fff_ffff);
        if (sb.elem_total > 0)
            send_beat(ACT_REMOVE, sb.elem_val[sb.elem_total - 1], 31'd0);
        in_valid <= 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("random_sample_multiset_top test passed");
        else
            $display("random_sample_multiset_top test failed");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("random_sample_multiset_top test failed");
        $finish;
    end
endmodule
